// File: hw/rtl/lss_pkg.sv
// Shared constants and types for the LIFO stack with search.
package lss_pkg;

    localparam int DEPTH  = 8;
    localparam int DATA_W = 32;
    localparam int MODE_W = 3;
    localparam int STAT_W = 2;
    localparam int POS_W  = 4;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH   = 3'd0,
        MODE_POP    = 3'd1,
        MODE_TOP    = 3'd2,
        MODE_BOTTOM = 3'd3,
        MODE_SEARCH = 3'd4,
        MODE_LIST   = 3'd5,
        MODE_COUNT  = 3'd6
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NO_MATCH = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SINGLE,
        S_SCAN,
        S_FLUSH
    } state_t;

endpackage

// File: hw/rtl/lss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // hold read data until the next read
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/lifo_stack_with_search_unit.sv
// Top level of the LIFO stack with search: control sequencer around the entry RAM.
// Takes one request at a time. Push, pop, reads and count are accepted, then executed
// against the registered RAM read; list and search walk the entry RAM one entry per
// cycle through its single read port. A result waits in the output register while
// m_ready is low; list holds its walk meanwhile, and search holds only when it has
// a further hit to give.
// Entries are not cleared at reset; only positions below the fill count reach the output.
module lifo_stack_with_search_unit
    import lss_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [MODE_W-1:0]        s_mode,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [STAT_W-1:0]        m_status,
    output logic signed [DATA_W-1:0] m_data,
    output logic [POS_W-1:0]         m_position,
    output logic [POS_W-1:0]         m_fill_count,
    output logic                     m_last
);

    state_t              state_reg, state_next;
    mode_t               mode_reg, mode_next;
    logic [DATA_W-1:0]   value_reg, value_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [CNT_W-1:0]    pend_pos_reg, pend_pos_next;

    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [DATA_W-1:0]   out_data_reg, out_data_next;
    logic [POS_W-1:0]    out_pos_reg, out_pos_next;
    logic [POS_W-1:0]    out_fill_reg, out_fill_next;
    logic                out_last_reg, out_last_next;

    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;

    logic                accept, out_free, empty, full, at_end, hit;
    logic [ADDR_W-1:0]   top_addr;
    logic [CNT_W-1:0]    cur_pos;

    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign top_addr = ADDR_W'(count_reg - CNT_W'(1));
    assign at_end   = (idx_reg == top_addr);
    assign hit      = (ram_rdata == value_reg);
    assign cur_pos  = CNT_W'(idx_reg) + CNT_W'(1);

    lss_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_mode)
                        MODE_PUSH, MODE_POP, MODE_TOP, MODE_BOTTOM, MODE_COUNT:
                            state_next = S_SINGLE;
                        MODE_SEARCH: state_next = empty ? S_FLUSH : S_SCAN;
                        MODE_LIST:   state_next = empty ? S_SINGLE : S_SCAN;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_SINGLE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                if (mode_reg == MODE_LIST) begin
                    if (out_free && idx_reg == '0) begin
                        state_next = S_IDLE;
                    end
                end else if (!(hit && pend_valid_reg && !out_free) && at_end) begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        mode_next       = mode_reg;
        value_next      = value_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_pos_next   = pend_pos_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[ADDR_W-1:0];
        ram_re          = 1'b0;
        ram_raddr       = top_addr;
        out_valid_next  = out_valid_reg && !m_ready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_pos_next    = out_pos_reg;
        out_fill_next   = out_fill_reg;
        out_last_next   = out_last_reg;
        s_ready         = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    mode_next       = mode_t'(s_mode);
                    value_next      = s_value;
                    pend_valid_next = 1'b0;
                    ram_re          = 1'b1;
                    case (s_mode)
                        MODE_BOTTOM, MODE_SEARCH: ram_raddr = '0;
                        default:                  ram_raddr = top_addr;
                    endcase
                    idx_next = (s_mode == MODE_SEARCH) ? '0 : top_addr;
                end
            end
            S_SINGLE: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_data_next   = '0;
                    out_pos_next    = '0;
                    out_last_next   = 1'b1;
                    case (mode_reg)
                        MODE_PUSH: begin
                            if (full) begin
                                out_status_next = ST_OVERFLOW;
                            end else begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_POP: begin
                            if (empty) begin
                                out_status_next = ST_EMPTY;
                            end else begin
                                out_data_next = ram_rdata;
                                count_next    = count_reg - CNT_W'(1);
                            end
                        end
                        MODE_TOP, MODE_BOTTOM, MODE_LIST: begin
                            if (empty) begin
                                out_status_next = ST_EMPTY;
                            end else begin
                                out_data_next = ram_rdata;
                            end
                        end
                        default: ;
                    endcase
                    out_fill_next = POS_W'(count_next);
                end
            end
            S_SCAN: begin
                if (mode_reg == MODE_LIST) begin
                    // emit entries top to bottom, one per cycle while the output register is free
                    if (out_free) begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_OK;
                        out_data_next   = ram_rdata;
                        out_pos_next    = POS_W'(cur_pos);
                        out_fill_next   = POS_W'(count_reg);
                        out_last_next   = (idx_reg == '0);
                        if (idx_reg != '0) begin
                            idx_next  = idx_reg - ADDR_W'(1);
                            ram_re    = 1'b1;
                            ram_raddr = idx_reg - ADDR_W'(1);
                        end
                    end
                end else if (!(hit && pend_valid_reg && !out_free)) begin
                    // a new hit releases the held one, which is therefore not the last
                    if (hit && pend_valid_reg) begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_OK;
                        out_data_next   = '0;
                        out_pos_next    = POS_W'(pend_pos_reg);
                        out_fill_next   = POS_W'(count_reg);
                        out_last_next   = 1'b0;
                    end
                    if (hit) begin
                        pend_valid_next = 1'b1;
                        pend_pos_next   = cur_pos;
                    end
                    if (!at_end) begin
                        idx_next  = idx_reg + ADDR_W'(1);
                        ram_re    = 1'b1;
                        ram_raddr = idx_reg + ADDR_W'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_valid_reg ? ST_OK : ST_NO_MATCH;
                    out_data_next   = '0;
                    out_pos_next    = pend_valid_reg ? POS_W'(pend_pos_reg) : '0;
                    out_fill_next   = POS_W'(count_reg);
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        mode_reg       <= mode_next;
        value_reg      <= value_next;
        idx_reg        <= idx_next;
        pend_pos_reg   <= pend_pos_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_pos_reg    <= out_pos_next;
        out_fill_reg   <= out_fill_next;
        out_last_reg   <= out_last_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = out_status_reg;
    assign m_data       = out_data_reg;
    assign m_position   = out_pos_reg;
    assign m_fill_count = out_fill_reg;
    assign m_last       = out_last_reg;

endmodule

// File: hw/rtl/lss_checker.sv
// Port-level assertions for the LIFO stack with search, bound to the top level.
module lss_checker
    import lss_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [STAT_W-1:0]        m_status,
    input logic signed [DATA_W-1:0] m_data,
    input logic [POS_W-1:0]         m_position,
    input logic [POS_W-1:0]         m_fill_count,
    input logic                     m_last
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data) && $stable(m_position)
            && $stable(m_status) && $stable(m_last))
        else $error("result changed while stalled");

    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_OVERFLOW |-> m_fill_count == POS_W'(DEPTH) && m_last)
        else $error("overflow reported on a stack that is not full");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EMPTY |-> m_fill_count == '0 && m_data == '0 && m_last)
        else $error("empty status with entries held");

    a_no_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_NO_MATCH |-> m_position == '0 && m_data == '0 && m_last)
        else $error("malformed no-match result");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_OK && m_position != '0 |-> m_position <= m_fill_count)
        else $error("position beyond fill count");

endmodule

bind lifo_stack_with_search_unit lss_checker u_lss_checker (.*);
